// ----- sv/srlc_pkg.sv -----
`default_nettype none

package srlc_pkg;

	// One character of a record line as it arrives.
	typedef struct packed {
		logic [7:0]  char_in;
		logic        line_end;
		logic [15:0] records_seen;
	} char_item_t;

	// One verdict per line.
	typedef struct packed {
		logic [2:0] error_code;
		logic [3:0] record_type;
		logic [7:0] byte_count;
	} result_item_t;

	// Everything the checker keeps between characters of one line.
	typedef struct packed {
		logic [9:0]  char_position;
		logic [3:0]  type_digit;
		logic [2:0]  first_error;
		logic [7:0]  running_sum;
		logic [7:0]  count_field;
		logic [3:0]  high_nibble;
		logic [8:0]  pair_total;
		logic [15:0] address_value;
	} line_state_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_digit_t;

	// Error codes, in the order the checks take precedence.
	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_NO_S      = 3'd1;
	localparam logic [2:0] ERR_BAD_TYPE  = 3'd2;
	localparam logic [2:0] ERR_BAD_HEX   = 3'd3;
	localparam logic [2:0] ERR_COUNT     = 3'd4;
	localparam logic [2:0] ERR_CHECKSUM  = 3'd5;
	localparam logic [2:0] ERR_REC_COUNT = 3'd6;

	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	localparam logic [9:0] POS_MAX    = 10'd1023;
	localparam logic [8:0] PAIR_MAX   = 9'd511;
	localparam logic [3:0] TYPE_COUNT = 4'd5;

	// Only 0-9 and A-F are hex digits; anything else decodes as zero.
	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		logic [7:0] t;
		d = '0;
		t = '0;
		if (c >= CH_0 && c <= CH_9) begin
			t = c - CH_0;
			d.valid = 1'b1;
			d.value = t[3:0];
		end else if (c >= CH_A && c <= CH_F) begin
			t = c - CH_A + HEX_TEN;
			d.valid = 1'b1;
			d.value = t[3:0];
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// ----- sv/srlc_stream_if.sv -----
`default_nettype none

interface srlc_stream_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/srec_line_checker.sv -----
`default_nettype none

// S-record line checker.
// The chars channel takes one ASCII character of a record line per item; the
// item with line_end set is the last character of the line, and records_seen
// is the expected record count, looked at only on a type 5 line. The results
// channel gives one item per line: the first failing check (leading S, type
// digit, hex digits, byte count, checksum, record count), the type digit and
// the byte count field.
// Timing: a character is taken into an input register and applied to the line
// state from there; a line's result is registered as its last character
// leaves the input register. One character is accepted every cycle unless
// a line end waits in the input register; the state update is a single short
// pass of logic from the input register to the state and result registers.
// When the results receiver stalls, the result waits in its output register
// while characters of the next line keep flowing in; only a second line end
// arriving behind an untaken result waits in the input register, and the
// chars channel then drops ready.
// Reset clears the line state and both valid flags; the block is ready for
// the first character of a line right after reset.
module srec_line_checker
	import srlc_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	srlc_stream_if.sink      chars,
	srlc_stream_if.source    results
);

	// Input stage.
	logic         valid_s1;
	char_item_t   item_s1;

	// Line state and the result waiting to be taken.
	line_state_t  state_q;
	line_state_t  state_nxt;
	result_item_t res_nxt;
	result_item_t res_q;
	logic         out_valid_q;

	logic         advance;
	logic         take_in;

	// The input item moves on unless it closes a line while the previous
	// result is still stuck in the output register.
	assign advance = valid_s1 && (!item_s1.line_end || !out_valid_q || results.ready);
	assign chars.ready = !valid_s1 || advance;
	assign take_in = chars.valid && chars.ready;

	srlc_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= chars.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.line_end) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.line_end) begin
			res_q <= res_nxt;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.payload = res_q;

	// A line end always leaves the line state cleared for the next line.
	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.line_end |=> state_q == '0)
		else $error("line state not cleared after line end");

	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.line_end |-> !out_valid_q || results.ready)
		else $error("pending result overwritten");

	// Only defined error codes are offered.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.error_code <= ERR_REC_COUNT)
		else $error("undefined error code");

	// A type 5 record count failure only comes from a type 5 line.
	a_rec_count_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.error_code == ERR_REC_COUNT |-> res_q.record_type == TYPE_COUNT)
		else $error("record count error on a line of another type");

endmodule

`default_nettype wire

// ----- sv/srlc_step.sv -----
`default_nettype none

// Applies one character to the line state and forms the line verdict.
module srlc_step
	import srlc_pkg::*;
(
	input  wire line_state_t  cur,
	input  wire char_item_t   item,
	output line_state_t       nxt,
	output result_item_t      res
);

	hex_digit_t  hex;
	logic [9:0]  pos;
	logic [2:0]  new_err;
	logic [7:0]  last_byte;
	logic [7:0]  type_tmp;
	logic [2:0]  verdict;

	assign pos = cur.char_position;
	assign hex = hex_decode(item.char_in);

	always_comb begin
		nxt       = cur;
		new_err   = ERR_OK;
		last_byte = '0;
		type_tmp  = item.char_in - CH_0;
		if (pos == 10'd0) begin
			if (item.char_in != CH_S) begin
				new_err = ERR_NO_S;
			end
		end else if (pos == 10'd1) begin
			if (item.char_in >= CH_0 && item.char_in <= CH_9) begin
				nxt.type_digit = type_tmp[3:0];
			end else begin
				nxt.type_digit = '0;
				new_err = ERR_BAD_TYPE;
			end
		end else begin
			if (!hex.valid) begin
				new_err = ERR_BAD_HEX;
			end
			last_byte = {cur.high_nibble, hex.value};
			if (pos[0]) begin
				if (pos == 10'd3) begin
					nxt.count_field = last_byte;
				end
				nxt.running_sum = cur.running_sum + last_byte;
				if (cur.pair_total != PAIR_MAX) begin
					nxt.pair_total = cur.pair_total + 9'd1;
				end
			end
			// Address digits sit at positions four to seven, most significant first.
			if (pos >= 10'd4 && pos <= 10'd7) begin
				unique case (pos[1:0])
					2'd0: nxt.address_value[15:12] = cur.address_value[15:12] | hex.value;
					2'd1: nxt.address_value[11:8]  = cur.address_value[11:8]  | hex.value;
					2'd2: nxt.address_value[7:4]   = cur.address_value[7:4]   | hex.value;
					2'd3: nxt.address_value[3:0]   = cur.address_value[3:0]   | hex.value;
					default: nxt.address_value = cur.address_value;
				endcase
			end
			nxt.high_nibble = hex.value;
		end
		if (cur.first_error == ERR_OK) begin
			nxt.first_error = new_err;
		end
		if (pos != POS_MAX) begin
			nxt.char_position = pos + 10'd1;
		end

		verdict = nxt.first_error;
		if (verdict == ERR_OK) begin
			priority if (pos == 10'd0) begin
				verdict = ERR_BAD_TYPE;
			end else if (pos < 10'd3) begin
				verdict = ERR_COUNT;
			end else if (({1'b0, nxt.count_field} + 9'd1) != nxt.pair_total) begin
				verdict = ERR_COUNT;
			end else if (cur.running_sum != ~last_byte) begin
				verdict = ERR_CHECKSUM;
			end else if (nxt.type_digit == TYPE_COUNT
				&& nxt.address_value != item.records_seen) begin
				verdict = ERR_REC_COUNT;
			end
		end
		res.error_code  = verdict;
		res.record_type = nxt.type_digit;
		res.byte_count  = nxt.count_field;

		// The line is finished: start the next one from a clean state.
		if (item.line_end) begin
			nxt = '0;
		end
	end

endmodule

`default_nettype wire
